// File: rtl/core/uts_pkg.sv
// Shared constants and types for the timestamp date check unit.
`timescale 1ns / 1ps
`default_nettype none
package uts_pkg;

   localparam int NUM_STAGES = 12;

   localparam logic signed [4:0] TZ_RESET = 5'sd8;

   // Reciprocals for exact division by constants: q = (x * R) >> K
   localparam logic [63:0] R_1000 = (64'd1 << 54) / 64'd1000 + 64'd1;
   localparam logic [63:0] R_675  = (64'd1 << 38) / 64'd675 + 64'd1;
   localparam logic [63:0] R_1460 = (64'd1 << 29) / 64'd1460 + 64'd1;
   localparam logic [63:0] R_365  = (64'd1 << 27) / 64'd365 + 64'd1;
   localparam logic [63:0] R_100  = (64'd1 << 16) / 64'd100 + 64'd1;
   localparam logic [63:0] R_153  = (64'd1 << 19) / 64'd153 + 64'd1;
   localparam logic [63:0] R_5    = (64'd1 << 14) / 64'd5 + 64'd1;
   localparam logic [63:0] R_60C  = (64'd1 << 23) / 64'd60 + 64'd1;
   localparam logic [63:0] R_60M  = (64'd1 << 17) / 64'd60 + 64'd1;

   // Bias that keeps shifted seconds non-negative: 86400 * 2^17
   localparam logic signed [35:0] T_BIAS = 36'sd11324620800;

   localparam logic [11:0] YEAR_LOW  = 12'd1970;
   localparam logic [11:0] YEAR_HIGH = 12'd2099;

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
   } pipe_ctl_type;

endpackage
`default_nettype wire

// File: rtl/core/uts_ctrl.sv
// Valid bits and per-stage advance chain of the conversion pipeline.
`timescale 1ns / 1ps
`default_nettype none
module uts_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output uts_pkg::pipe_ctl_type ctl
);
   import uts_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] en;

   // a stage advances when it is empty or its successor advances
   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (en[k]) begin
            valid_in[k] = (k == 0) ? req_tvalid : valid_ff[(k == 0) ? 0 : k - 1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.en     = en;
   assign req_tready = en[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];

endmodule
`default_nettype wire

// File: rtl/core/uts_front.sv
// Length check, millisecond scaling, zone offset and day split (stages 1 to 4).
`timescale 1ns / 1ps
`default_nettype none
module uts_front (
   input  wire logic                 clock,
   input  wire uts_pkg::pipe_ctl_type ctl,
   input  wire logic [63:0]          timestamp,
   input  wire logic signed [4:0]    tz_offset_hours,
   output logic [17:0]               days_u,
   output logic [34:0]               t_biased,
   output logic                      millis,
   output logic                      len_ok
);
   import uts_pkg::*;

   // stage 1
   logic        s1_ok_ff, s1_neg_ff, s1_ms_ff;
   logic [43:0] s1_mag_ff;
   logic        s1_ok_in, s1_ms_in;
   logic [63:0] mag64;
   logic        pos10, neg10, pos13, neg13;

   always_comb begin
      pos10 = $signed(timestamp) >= 64'sd1000000000 &&
              $signed(timestamp) <= 64'sd9999999999;
      neg10 = $signed(timestamp) <= -64'sd100000000 &&
              $signed(timestamp) >= -64'sd999999999;
      pos13 = $signed(timestamp) >= 64'sd1000000000000 &&
              $signed(timestamp) <= 64'sd9999999999999;
      neg13 = $signed(timestamp) <= -64'sd100000000000 &&
              $signed(timestamp) >= -64'sd999999999999;
      s1_ms_in = pos13 || neg13;
      s1_ok_in = pos10 || neg10 || s1_ms_in;
      mag64    = timestamp[63] ? (~timestamp + 64'd1) : timestamp;
   end

   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         s1_ok_ff  <= s1_ok_in;
         s1_ms_ff  <= s1_ms_in;
         s1_neg_ff <= timestamp[63];
         s1_mag_ff <= mag64[43:0];
      end
   end

   // stage 2: partial products of magnitude * (2^54 / 1000)
   logic [43:0] s2_pp_ll_ff, s2_pp_hl_ff;
   logic [44:0] s2_pp_lh_ff, s2_pp_hh_ff;
   logic [43:0] s2_mag_ff;
   logic        s2_ok_ff, s2_neg_ff, s2_ms_ff;
   logic [43:0] s2_pp_ll_in, s2_pp_hl_in;
   logic [44:0] s2_pp_lh_in, s2_pp_hh_in;

   always_comb begin
      s2_pp_ll_in = {22'd0, s1_mag_ff[21:0]} * {22'd0, R_1000[21:0]};
      s2_pp_hl_in = {22'd0, s1_mag_ff[43:22]} * {22'd0, R_1000[21:0]};
      s2_pp_lh_in = {23'd0, s1_mag_ff[21:0]} * {22'd0, R_1000[44:22]};
      s2_pp_hh_in = {23'd0, s1_mag_ff[43:22]} * {22'd0, R_1000[44:22]};
   end

   always_ff @(posedge clock) begin
      if (ctl.en[1]) begin
         s2_pp_ll_ff <= s2_pp_ll_in;
         s2_pp_hl_ff <= s2_pp_hl_in;
         s2_pp_lh_ff <= s2_pp_lh_in;
         s2_pp_hh_ff <= s2_pp_hh_in;
         s2_mag_ff   <= s1_mag_ff;
         s2_ok_ff    <= s1_ok_ff;
         s2_neg_ff   <= s1_neg_ff;
         s2_ms_ff    <= s1_ms_ff;
      end
   end

   // stage 3: seconds, sign, zone offset and bias
   logic [34:0]        s3_tb_ff;
   logic               s3_ok_ff, s3_ms_ff;
   logic [89:0]        psum;
   logic [33:0]        sec34;
   logic signed [35:0] tsgn, toff, s3_tb_full;
   logic [34:0]        s3_tb_in;

   always_comb begin
      psum = 90'(s2_pp_ll_ff) + (90'(s2_pp_lh_ff) << 22) + (90'(s2_pp_hl_ff) << 22)
           + (90'(s2_pp_hh_ff) << 44);
      sec34 = s2_ms_ff ? psum[87:54] : s2_mag_ff[33:0];
      tsgn  = s2_neg_ff ? -$signed({2'b00, sec34}) : $signed({2'b00, sec34});
      toff  = 36'(tz_offset_hours) * 36'sd3600;
      s3_tb_full = tsgn + toff + T_BIAS;
      s3_tb_in   = s3_tb_full[34:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.en[2]) begin
         s3_tb_ff <= s3_tb_in;
         s3_ok_ff <= s2_ok_ff;
         s3_ms_ff <= s2_ms_ff;
      end
   end

   // stage 4: biased day number = tb / 86400 = (tb >> 7) / 675
   logic [17:0] s4_days_ff;
   logic [34:0] s4_tb_ff;
   logic        s4_ok_ff, s4_ms_ff;
   logic [56:0] dprod;

   always_comb begin
      dprod = 57'(s3_tb_ff[34:7]) * 57'(R_675[28:0]);
   end

   always_ff @(posedge clock) begin
      if (ctl.en[3]) begin
         s4_days_ff <= dprod[55:38];
         s4_tb_ff   <= s3_tb_ff;
         s4_ok_ff   <= s3_ok_ff;
         s4_ms_ff   <= s3_ms_ff;
      end
   end

   assign days_u   = s4_days_ff;
   assign t_biased = s4_tb_ff;
   assign millis   = s4_ms_ff;
   assign len_ok   = s4_ok_ff;

endmodule
`default_nettype wire

// File: rtl/core/uts_cal.sv
// Day number to civil date and seconds of day to clock time (stages 5 to 12).
`timescale 1ns / 1ps
`default_nettype none
module uts_cal (
   input  wire logic                 clock,
   input  wire uts_pkg::pipe_ctl_type ctl,
   input  wire logic [17:0]          days_u,
   input  wire logic [34:0]          t_biased,
   input  wire logic                 millis,
   input  wire logic                 len_ok,
   output logic                      valid_res,
   output logic                      is_millis,
   output logic [11:0]               cal_year,
   output logic [3:0]                cal_month,
   output logic [4:0]                cal_day,
   output logic [4:0]                cal_hour,
   output logic [5:0]                cal_minute,
   output logic [5:0]                cal_second
);
   import uts_pkg::*;

   typedef struct packed {
      logic        ms;
      logic        ok;
      logic        era5;
      logic [17:0] doe;
   } carry_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } tod_type;

   // stage 5: seconds of day, day of era
   carry_type   s5_c_ff;
   logic [16:0] s5_clk_ff;
   carry_type   s5_c_in;
   logic [34:0] clk_full;
   logic [19:0] z;

   always_comb begin
      clk_full     = t_biased - 35'(days_u) * 35'd86400;
      z            = 20'(days_u) + 20'd588396;
      s5_c_in.ms   = millis;
      s5_c_in.ok   = len_ok;
      s5_c_in.era5 = z >= 20'd730485;
      s5_c_in.doe  = 18'(z - (s5_c_in.era5 ? 20'd730485 : 20'd584388));
   end

   always_ff @(posedge clock) begin
      if (ctl.en[4]) begin
         s5_c_ff   <= s5_c_in;
         s5_clk_ff <= clk_full[16:0];
      end
   end

   // stage 6: year-of-era numerator, minute of day
   carry_type   s6_c_ff;
   logic [17:0] s6_num_ff;
   logic [16:0] s6_clk_ff;
   logic [10:0] s6_mod_ff;
   logic [36:0] p1460;
   logic [34:0] pmod;
   logic [2:0]  c36524;
   logic [17:0] s6_num_in;

   always_comb begin
      p1460  = 37'(s5_c_ff.doe) * 37'(R_1460[18:0]);
      c36524 = 3'(s5_c_ff.doe >= 18'd36524) + 3'(s5_c_ff.doe >= 18'd73048)
             + 3'(s5_c_ff.doe >= 18'd109572) + 3'(s5_c_ff.doe >= 18'd146096);
      s6_num_in = s5_c_ff.doe - 18'(p1460[36:29]) + 18'(c36524)
                - 18'(s5_c_ff.doe == 18'd146096);
      pmod   = 35'(s5_clk_ff) * 35'(R_60C[17:0]);
   end

   always_ff @(posedge clock) begin
      if (ctl.en[5]) begin
         s6_c_ff   <= s5_c_ff;
         s6_num_ff <= s6_num_in;
         s6_clk_ff <= s5_clk_ff;
         s6_mod_ff <= pmod[33:23];
      end
   end

   // stage 7: year of era, hour, second
   carry_type   s7_c_ff;
   logic [8:0]  s7_yoe_ff;
   logic [10:0] s7_mod_ff;
   logic [4:0]  s7_hour_ff;
   logic [5:0]  s7_sec_ff;
   logic [44:0] p365;
   logic [22:0] phour;
   logic [16:0] sec_full;

   always_comb begin
      p365     = 45'(s6_num_ff) * 45'(R_365[18:0]);
      phour    = 23'(s6_mod_ff) * 23'(R_60M[11:0]);
      sec_full = s6_clk_ff - 17'(s6_mod_ff) * 17'd60;
   end

   always_ff @(posedge clock) begin
      if (ctl.en[6]) begin
         s7_c_ff    <= s6_c_ff;
         s7_yoe_ff  <= p365[35:27];
         s7_mod_ff  <= s6_mod_ff;
         s7_hour_ff <= phour[21:17];
         s7_sec_ff  <= sec_full[5:0];
      end
   end

   // stage 8: century count, minute
   carry_type   s8_c_ff;
   logic [8:0]  s8_yoe_ff;
   logic [2:0]  s8_y100_ff;
   tod_type     s8_tod_ff;
   tod_type     s8_tod_in;
   logic [18:0] p100;
   logic [10:0] min_full;

   always_comb begin
      p100             = 19'(s7_yoe_ff) * 19'(R_100[9:0]);
      min_full         = s7_mod_ff - 11'(s7_hour_ff) * 11'd60;
      s8_tod_in.hour   = s7_hour_ff;
      s8_tod_in.minute = min_full[5:0];
      s8_tod_in.second = s7_sec_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.en[7]) begin
         s8_c_ff    <= s7_c_ff;
         s8_yoe_ff  <= s7_yoe_ff;
         s8_y100_ff <= p100[18:16];
         s8_tod_ff  <= s8_tod_in;
      end
   end

   // stage 9: day of year (March based)
   logic        s9_ms_ff, s9_ok_ff, s9_era5_ff;
   logic [8:0]  s9_yoe_ff, s9_doy_ff;
   tod_type     s9_tod_ff;
   logic [17:0] doy_full;

   always_comb begin
      doy_full = s8_c_ff.doe - (18'(s8_yoe_ff) * 18'd365 + 18'(s8_yoe_ff[8:2])
               - 18'(s8_y100_ff));
   end

   always_ff @(posedge clock) begin
      if (ctl.en[8]) begin
         s9_ms_ff   <= s8_c_ff.ms;
         s9_ok_ff   <= s8_c_ff.ok;
         s9_era5_ff <= s8_c_ff.era5;
         s9_yoe_ff  <= s8_yoe_ff;
         s9_doy_ff  <= doy_full[8:0];
         s9_tod_ff  <= s8_tod_ff;
      end
   end

   // stage 10: March-based month index
   logic        s10_ms_ff, s10_ok_ff, s10_era5_ff;
   logic [8:0]  s10_yoe_ff, s10_doy_ff;
   logic [3:0]  s10_mp_ff;
   tod_type     s10_tod_ff;
   logic [10:0] t5;
   logic [29:0] p153;

   always_comb begin
      t5   = 11'(s9_doy_ff) * 11'd5 + 11'd2;
      p153 = 30'(t5) * 30'(R_153[11:0]);
   end

   always_ff @(posedge clock) begin
      if (ctl.en[9]) begin
         s10_ms_ff   <= s9_ms_ff;
         s10_ok_ff   <= s9_ok_ff;
         s10_era5_ff <= s9_era5_ff;
         s10_yoe_ff  <= s9_yoe_ff;
         s10_doy_ff  <= s9_doy_ff;
         s10_mp_ff   <= p153[22:19];
         s10_tod_ff  <= s9_tod_ff;
      end
   end

   // stage 11: month start term
   logic        s11_ms_ff, s11_ok_ff, s11_era5_ff;
   logic [8:0]  s11_yoe_ff, s11_doy_ff;
   logic [3:0]  s11_mp_ff;
   logic [10:0] s11_t2_ff;
   tod_type     s11_tod_ff;

   always_ff @(posedge clock) begin
      if (ctl.en[10]) begin
         s11_ms_ff   <= s10_ms_ff;
         s11_ok_ff   <= s10_ok_ff;
         s11_era5_ff <= s10_era5_ff;
         s11_yoe_ff  <= s10_yoe_ff;
         s11_doy_ff  <= s10_doy_ff;
         s11_mp_ff   <= s10_mp_ff;
         s11_t2_ff   <= 11'(s10_mp_ff) * 11'd153 + 11'd2;
         s11_tod_ff  <= s10_tod_ff;
      end
   end

   // stage 12: day, month, year, range check; output register
   logic        s12_valid_ff, s12_ms_ff;
   logic [11:0] s12_year_ff;
   logic [3:0]  s12_month_ff;
   logic [4:0]  s12_day_ff;
   tod_type     s12_tod_ff;
   logic [24:0] p5;
   logic [8:0]  day_full;
   logic [3:0]  month_in;
   logic [11:0] year_in;
   logic        in_range;

   always_comb begin
      p5       = 25'(s11_t2_ff) * 25'(R_5[11:0]);
      day_full = s11_doy_ff - p5[22:14] + 9'd1;
      month_in = (s11_mp_ff < 4'd10) ? s11_mp_ff + 4'd3 : s11_mp_ff - 4'd9;
      year_in  = 12'(s11_yoe_ff) + (s11_era5_ff ? 12'd2000 : 12'd1600)
               + 12'(month_in <= 4'd2);
      in_range = year_in >= YEAR_LOW && year_in <= YEAR_HIGH;
   end

   always_ff @(posedge clock) begin
      if (ctl.en[11]) begin
         if (s11_ok_ff) begin
            s12_valid_ff <= in_range;
            s12_ms_ff    <= s11_ms_ff;
            s12_year_ff  <= year_in;
            s12_month_ff <= month_in;
            s12_day_ff   <= day_full[4:0];
            s12_tod_ff   <= s11_tod_ff;
         end else begin
            s12_valid_ff <= 1'b0;
            s12_ms_ff    <= 1'b0;
            s12_year_ff  <= '0;
            s12_month_ff <= '0;
            s12_day_ff   <= '0;
            s12_tod_ff   <= '0;
         end
      end
   end

   assign valid_res  = s12_valid_ff;
   assign is_millis  = s12_ms_ff;
   assign cal_year   = s12_year_ff;
   assign cal_month  = s12_month_ff;
   assign cal_day    = s12_day_ff;
   assign cal_hour   = s12_tod_ff.hour;
   assign cal_minute = s12_tod_ff.minute;
   assign cal_second = s12_tod_ff.second;

endmodule
`default_nettype wire

// File: rtl/core/unix_timestamp_date_check_unit.sv
// Top level of the Unix timestamp check and calendar conversion unit.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   req_* carries one signed 64-bit Unix timestamp per transaction. Its decimal
//   text must be 10 characters (seconds) or 13 (milliseconds), sign included.
//   rsp_* returns one transaction per request, in order: the Gregorian date and
//   clock time after adding the zone offset, plus a valid flag (year 1970..2099)
//   and a milliseconds flag. A rejected length returns all zeros.
//   csr_wr_en / csr_wr_data set the signed zone offset in hours; write only
//   while no transaction is in flight.
// Pipeline and rate:
//   12 register stages: length check, millisecond scaling, offset, day split,
//   then the civil date chain of constant reciprocal multiplies. One
//   transaction may enter every cycle while the pipeline is not stalled.
// Reset:
//   Synchronous, active high. Empties the pipeline and sets the offset to +8.
// Back-pressure:
//   Each stage holds while its successor is full and stalled, so empty stages
//   keep filling while rsp_tready is low; nothing is dropped or repeated.
module unix_timestamp_date_check_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: tdata[63:0] = timestamp
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,
   // response: tuser[0] = valid_res, tuser[1] = is_millis
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // response: tdata[11:0] cal_year, [15:12] cal_month, [20:16] cal_day,
   //           [25:21] cal_hour, [31:26] cal_minute, [37:32] cal_second, rest 0
   output logic [39:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser,
   // configuration: tz_offset_hours, signed
   input  wire logic        csr_wr_en,
   input  wire logic [4:0]  csr_wr_data
);
   import uts_pkg::*;

   pipe_ctl_type       ctl;
   logic signed [4:0]  tz_ff;
   logic [17:0]        days_u;
   logic [34:0]        t_biased;
   logic               millis, len_ok;
   logic               valid_res, is_millis;
   logic [11:0]        cal_year;
   logic [3:0]         cal_month;
   logic [4:0]         cal_day, cal_hour;
   logic [5:0]         cal_minute, cal_second;

   // hold the zone offset; the 5-bit value is used as written
   always_ff @(posedge clock) begin
      if (reset) begin
         tz_ff <= TZ_RESET;
      end else if (csr_wr_en) begin
         tz_ff <= $signed(csr_wr_data);
      end
   end

   uts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl)
   );

   uts_front u_front (
      .clock           (clock),
      .ctl             (ctl),
      .timestamp       (req_tdata),
      .tz_offset_hours (tz_ff),
      .days_u          (days_u),
      .t_biased        (t_biased),
      .millis          (millis),
      .len_ok          (len_ok)
   );

   uts_cal u_cal (
      .clock      (clock),
      .ctl        (ctl),
      .days_u     (days_u),
      .t_biased   (t_biased),
      .millis     (millis),
      .len_ok     (len_ok),
      .valid_res  (valid_res),
      .is_millis  (is_millis),
      .cal_year   (cal_year),
      .cal_month  (cal_month),
      .cal_day    (cal_day),
      .cal_hour   (cal_hour),
      .cal_minute (cal_minute),
      .cal_second (cal_second)
   );

   // pack the response fields, lowest first
   assign rsp_tdata = {2'b00, cal_second, cal_minute, cal_hour, cal_day, cal_month, cal_year};
   assign rsp_tuser = {is_millis, valid_res};

endmodule
`default_nettype wire

// File: rtl/core/uts_checker.sv
// Port-level checks for the timestamp date check unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module uts_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_year_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata[11:0] >= 12'd1970 && rsp_tdata[11:0] <= 12'd2099)
      else $error("valid flag with year out of range");

   a_fields_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata[15:12] >= 4'd1 && rsp_tdata[15:12] <= 4'd12 &&
         rsp_tdata[20:16] >= 5'd1 && rsp_tdata[25:21] <= 5'd23 &&
         rsp_tdata[31:26] <= 6'd59 && rsp_tdata[37:32] <= 6'd59)
      else $error("calendar field out of range");

endmodule

bind unix_timestamp_date_check_unit uts_checker u_uts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
